// File: rtl/core/gpbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPU port bridge register package
// Shared payload types, access codes, register selects and constants.
// ----------------------------------------------------------------------------
package gpbr_pkg;

  localparam int DATA_FIFO_DEPTH_DEF = 32;
  localparam int CMD_FIFO_DEPTH_DEF  = 8;
  localparam int DATA_FIFO_SPARE_DEF = 1;

  localparam logic [1:0] OP_GPU_WR  = 2'd0;
  localparam logic [1:0] OP_GPU_RD  = 2'd1;
  localparam logic [1:0] OP_HOST_WR = 2'd2;
  localparam logic [1:0] OP_HOST_RD = 2'd3;

  localparam logic [2:0] SEL_GPU_DATA  = 3'd0;
  localparam logic [2:0] SEL_GPU_STAT  = 3'd1;
  localparam logic [2:0] SEL_HOST_STAT = 3'd0;
  localparam logic [2:0] SEL_HOST_CTRL = 3'd1;
  localparam logic [2:0] SEL_RESP_E2   = 3'd2;
  localparam logic [2:0] SEL_RESP_E3   = 3'd3;
  localparam logic [2:0] SEL_RESP_E4   = 3'd4;
  localparam logic [2:0] SEL_RESP_E5   = 3'd5;
  localparam logic [2:0] SEL_CMD_FIFO  = 3'd6;
  localparam logic [2:0] SEL_DATA_FIFO = 3'd7;

  localparam logic [1:0] CMD_CLASS_IMM = 2'd1;
  localparam logic [5:0] CMD_IRQ_ACK   = 6'h02;
  localparam logic [5:0] CMD_DMA_DIR   = 6'h04;

  localparam logic [1:0] DIR_OFF  = 2'd0;
  localparam logic [1:0] DIR_FIFO = 2'd1;
  localparam logic [1:0] DIR_RDMA = 2'd2;
  localparam logic [1:0] DIR_SEND = 2'd3;

  localparam logic [7:0]  IRQ1_TAG  = 8'h1F;
  localparam logic [31:0] MASK_E2   = 32'h000F_FFFF;
  localparam logic [31:0] MASK_E3E4 = 32'h0007_FFFF;
  localparam logic [31:0] MASK_E5   = 32'h003F_FFFF;

  localparam int ST_IRQ1     = 24;
  localparam int ST_DREQ     = 25;
  localparam int ST_RSEND    = 27;
  localparam int ST_RDMA     = 28;
  localparam int ST_DDIR_LO  = 29;
  localparam int CT_GPU_RDY  = 4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  reg_select;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        host_irq;
    logic        iop_irq;
    logic        fifo_overflow;
    logic        fifo_underflow;
    logic        bad_access;
  } out_item_t;

endpackage

// File: rtl/core/gpu_port_bridge_regs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPU port bridge register core
// Data and command FIFOs, status, control and response registers between a
// GPU-style port pair and a host bus.
// ----------------------------------------------------------------------------
// The block takes one bus access per cycle and returns one result per access.
// An access is accepted into an issue stage, where FIFO pointers and fill
// counts are updated and the FIFO memory is read; when the output register
// is free, the register update and the result are formed from the issue
// stage and loaded into the output register, and a stalled output holds the
// issue stage and the input. Both FIFO stores are memories with registered
// reads and need no clearing pass.
module gpu_port_bridge_regs_core
  import gpbr_pkg::*;
#(
  parameter int DATA_FIFO_DEPTH = DATA_FIFO_DEPTH_DEF,
  parameter int CMD_FIFO_DEPTH  = CMD_FIFO_DEPTH_DEF,
  parameter int DATA_FIFO_SPARE = DATA_FIFO_SPARE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int DAW = $clog2(DATA_FIFO_DEPTH);
  localparam int DFW = $clog2(DATA_FIFO_DEPTH + 1);
  localparam int CAW = $clog2(CMD_FIFO_DEPTH);
  localparam int CFW = $clog2(CMD_FIFO_DEPTH + 1);

  typedef struct packed {
    logic [1:0]     opcode;
    logic [2:0]     reg_select;
    logic [31:0]    write_data;
    logic           data_pop_ok;
    logic           cmd_pop_ok;
    logic           host_irq;
    logic           fifo_overflow;
    logic           fifo_underflow;
    logic           bad_access;
    logic [DFW-1:0] data_fill;
    logic [CFW-1:0] cmd_fill;
  } issue_t;

  logic [31:0]    data_mem [DATA_FIFO_DEPTH];
  logic [31:0]    cmd_mem  [CMD_FIFO_DEPTH];
  logic [31:0]    data_rd_r;
  logic [31:0]    cmd_rd_r;

  logic [DAW-1:0] dhead_r, dhead_nxt, dtail_r, dtail_nxt;
  logic [DFW-1:0] dfill_r, dfill_nxt;
  logic [CAW-1:0] chead_r, chead_nxt, ctail_r, ctail_nxt;
  logic [CFW-1:0] cfill_r, cfill_nxt;

  logic           s1_valid_r;
  issue_t         s1_r, s1_nxt;
  logic           s1_adv;
  logic           in_xfer;

  logic [31:0]    status_r, status_nxt;
  logic [31:0]    ctrl_r, ctrl_nxt;
  logic [31:0]    resp_r [4];
  logic [31:0]    resp_nxt [4];
  logic [31:0]    lrw_r, lrw_nxt;

  logic           out_valid_r;
  out_item_t      out_r, out_nxt;

  logic is_dpush, is_dpop, is_cpush, is_cpop;
  logic dpush_do, dpop_do, cpush_do, cpop_do;
  logic dfull, dempty, cfull, cempty;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  assign dfull  = (32'(dfill_r) == 32'(DATA_FIFO_DEPTH));
  assign dempty = (dfill_r == '0);
  assign cfull  = (32'(cfill_r) == 32'(CMD_FIFO_DEPTH));
  assign cempty = (cfill_r == '0);

  always_comb begin
    is_dpush = ((in_data.opcode == OP_GPU_WR) && (in_data.reg_select == SEL_GPU_DATA)) ||
               ((in_data.opcode == OP_HOST_WR) && (in_data.reg_select == SEL_DATA_FIFO));
    is_dpop  = ((in_data.opcode == OP_GPU_RD) && (in_data.reg_select == SEL_GPU_DATA)) ||
               ((in_data.opcode == OP_HOST_RD) && (in_data.reg_select == SEL_DATA_FIFO));
    is_cpush = (in_data.opcode == OP_GPU_WR) && (in_data.reg_select == SEL_GPU_STAT) &&
               (in_data.write_data[29:28] != CMD_CLASS_IMM);
    is_cpop  = (in_data.opcode == OP_HOST_RD) && (in_data.reg_select == SEL_CMD_FIFO);

    dpush_do = in_xfer && is_dpush && !dfull;
    dpop_do  = in_xfer && is_dpop && !dempty;
    cpush_do = in_xfer && is_cpush && !cfull;
    cpop_do  = in_xfer && is_cpop && !cempty;

    dhead_nxt = dhead_r;
    dtail_nxt = dtail_r;
    dfill_nxt = dfill_r;
    chead_nxt = chead_r;
    ctail_nxt = ctail_r;
    cfill_nxt = cfill_r;
    if (dpush_do) begin
      dhead_nxt = (dhead_r == DAW'(DATA_FIFO_DEPTH - 1)) ? '0 : dhead_r + 1'b1;
      dfill_nxt = dfill_r + 1'b1;
    end
    if (dpop_do) begin
      dtail_nxt = (dtail_r == DAW'(DATA_FIFO_DEPTH - 1)) ? '0 : dtail_r + 1'b1;
      dfill_nxt = dfill_r - 1'b1;
    end
    if (cpush_do) begin
      chead_nxt = (chead_r == CAW'(CMD_FIFO_DEPTH - 1)) ? '0 : chead_r + 1'b1;
      cfill_nxt = cfill_r + 1'b1;
    end
    if (cpop_do) begin
      ctail_nxt = (ctail_r == CAW'(CMD_FIFO_DEPTH - 1)) ? '0 : ctail_r + 1'b1;
      cfill_nxt = cfill_r - 1'b1;
    end

    s1_nxt.opcode         = in_data.opcode;
    s1_nxt.reg_select     = in_data.reg_select;
    s1_nxt.write_data     = in_data.write_data;
    s1_nxt.data_pop_ok    = is_dpop && !dempty;
    s1_nxt.cmd_pop_ok     = is_cpop && !cempty;
    s1_nxt.host_irq       = is_cpush;
    s1_nxt.fifo_overflow  = (is_dpush && dfull) || (is_cpush && cfull);
    s1_nxt.fifo_underflow = is_cpop && cempty;
    s1_nxt.bad_access     = (((in_data.opcode == OP_GPU_WR) || (in_data.opcode == OP_GPU_RD)) &&
                             (in_data.reg_select > SEL_GPU_STAT)) ||
                            ((in_data.opcode == OP_HOST_WR) &&
                             (in_data.reg_select == SEL_CMD_FIFO));
    s1_nxt.data_fill      = dfill_nxt;
    s1_nxt.cmd_fill       = cfill_nxt;
  end

  always_ff @(posedge clk) begin
    if (dpush_do) begin
      data_mem[dhead_r] <= in_data.write_data;
    end
    if (dpop_do) begin
      data_rd_r <= data_mem[dtail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cpush_do) begin
      cmd_mem[chead_r] <= in_data.write_data;
    end
    if (cpop_do) begin
      cmd_rd_r <= cmd_mem[ctail_r];
    end
  end

  always_comb begin
    logic [31:0] w;
    logic [4:0]  dcnt;
    logic [2:0]  ccnt;
    logic        req;

    status_nxt = status_r;
    ctrl_nxt   = ctrl_r;
    lrw_nxt    = lrw_r;
    for (int i = 0; i < 4; i++) begin
      resp_nxt[i] = resp_r[i];
    end
    w    = '0;
    req  = 1'b0;
    dcnt = (32'(s1_r.data_fill) >= 32'h1F) ? 5'h1F : 5'(s1_r.data_fill);
    ccnt = (32'(s1_r.cmd_fill) >= 32'h7) ? 3'h7 : 3'(s1_r.cmd_fill);

    out_nxt.read_data      = '0;
    out_nxt.host_irq       = s1_r.host_irq;
    out_nxt.iop_irq        = 1'b0;
    out_nxt.fifo_overflow  = s1_r.fifo_overflow;
    out_nxt.fifo_underflow = s1_r.fifo_underflow;
    out_nxt.bad_access     = s1_r.bad_access;

    case (s1_r.opcode)
      OP_GPU_WR: begin
        if ((s1_r.reg_select == SEL_GPU_STAT) &&
            (s1_r.write_data[29:28] == CMD_CLASS_IMM)) begin
          case (s1_r.write_data[2:0])
            SEL_RESP_E2: lrw_nxt = resp_r[0] & MASK_E2;
            SEL_RESP_E3: lrw_nxt = resp_r[1] & MASK_E3E4;
            SEL_RESP_E4: lrw_nxt = resp_r[2] & MASK_E3E4;
            SEL_RESP_E5: lrw_nxt = resp_r[3] & MASK_E5;
            default:     lrw_nxt = lrw_r;
          endcase
        end
      end
      OP_GPU_RD: begin
        if (s1_r.reg_select == SEL_GPU_STAT) begin
          status_nxt[ST_RSEND]  = ctrl_r[CT_GPU_RDY];
          out_nxt.read_data     = status_nxt;
        end
      end
      OP_HOST_WR: begin
        unique case (s1_r.reg_select)
          SEL_HOST_STAT: status_nxt = s1_r.write_data;
          SEL_HOST_CTRL: ctrl_nxt   = s1_r.write_data;
          SEL_RESP_E2, SEL_RESP_E3, SEL_RESP_E4, SEL_RESP_E5: begin
            resp_nxt[2'(s1_r.reg_select - SEL_RESP_E2)] = s1_r.write_data;
          end
          default: ;
        endcase
      end
      default: begin
        unique case (s1_r.reg_select)
          SEL_HOST_STAT: out_nxt.read_data = status_r;
          SEL_HOST_CTRL: begin
            ctrl_nxt[12:8]    = dcnt;
            ctrl_nxt[18:16]   = ccnt;
            out_nxt.read_data = ctrl_nxt;
          end
          SEL_RESP_E2, SEL_RESP_E3, SEL_RESP_E4, SEL_RESP_E5: begin
            out_nxt.read_data = resp_r[2'(s1_r.reg_select - SEL_RESP_E2)];
          end
          SEL_CMD_FIFO: begin
            if (s1_r.cmd_pop_ok) begin
              w = cmd_rd_r;
              out_nxt.read_data = w;
              if (w[29:24] == CMD_IRQ_ACK) begin
                status_nxt[ST_IRQ1] = 1'b0;
              end else if (w[29:24] == CMD_DMA_DIR) begin
                status_nxt[ST_DDIR_LO+1:ST_DDIR_LO] = w[1:0];
                case (w[1:0])
                  DIR_FIFO: req = (32'(s1_r.data_fill) <
                                   32'(DATA_FIFO_DEPTH - DATA_FIFO_SPARE));
                  DIR_RDMA: req = status_r[ST_RDMA];
                  DIR_SEND: req = status_r[ST_RSEND];
                  default:  req = 1'b0;
                endcase
                status_nxt[ST_DREQ] = req;
              end
            end
          end
          default: ;
        endcase
      end
    endcase

    if (s1_r.data_pop_ok) begin
      out_nxt.read_data = data_rd_r;
      if (data_rd_r[31:24] == IRQ1_TAG) begin
        status_nxt[ST_IRQ1] = 1'b1;
        out_nxt.iop_irq     = 1'b1;
      end
    end else if ((((s1_r.opcode == OP_GPU_RD) && (s1_r.reg_select == SEL_GPU_DATA)) ||
                  ((s1_r.opcode == OP_HOST_RD) && (s1_r.reg_select == SEL_DATA_FIFO)))) begin
      out_nxt.read_data = lrw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dhead_r     <= '0;
      dtail_r     <= '0;
      dfill_r     <= '0;
      chead_r     <= '0;
      ctail_r     <= '0;
      cfill_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= '0;
      ctrl_r      <= '0;
      lrw_r       <= '0;
      for (int i = 0; i < 4; i++) begin
        resp_r[i] <= '0;
      end
    end else begin
      dhead_r <= dhead_nxt;
      dtail_r <= dtail_nxt;
      dfill_r <= dfill_nxt;
      chead_r <= chead_nxt;
      ctail_r <= ctail_nxt;
      cfill_r <= cfill_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        status_r    <= status_nxt;
        ctrl_r      <= ctrl_nxt;
        lrw_r       <= lrw_nxt;
        for (int i = 0; i < 4; i++) begin
          resp_r[i] <= resp_nxt[i];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_dfill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(dfill_r) <= 32'(DATA_FIFO_DEPTH))
    else $error("data FIFO fill count exceeds depth");

  a_cfill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cfill_r) <= 32'(CMD_FIFO_DEPTH))
    else $error("command FIFO fill count exceeds depth");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("issue stage overwritten while stalled");

  a_iop_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.iop_irq) |-> (out_data.read_data[31:24] == IRQ1_TAG))
    else $error("IOP interrupt without IRQ1 command word");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.fifo_underflow && (out_data.fifo_overflow || out_data.host_irq)))
    else $error("conflicting result flags");
`endif

endmodule

// File: bench/tb_gpu_port_bridge_regs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPU port bridge register core testbench
// Drives GPU-side and host-side bus accesses through the valid/ready input
// channel and checks every result against an in-bench model of the FIFOs,
// status, control and response registers. It runs a directed opening, then
// random accesses with FIFO fill and drain bursts under three flow-control
// profiles.
// ----------------------------------------------------------------------------
module tb_gpu_port_bridge_regs_core
  import gpbr_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  localparam int ACC_DATA_PUSH = 0;
  localparam int ACC_DATA_POP  = 1;
  localparam int ACC_CMD_PUSH  = 2;
  localparam int ACC_IMM_QUERY = 3;
  localparam int ACC_CMD_POP   = 4;
  localparam int ACC_HOST_REG  = 5;
  localparam int ACC_NOISE     = 6;

  class bridge_scoreboard;
    logic [31:0] data_words [DATA_FIFO_DEPTH_DEF];
    logic [4:0]  data_wr_ptr;
    logic [4:0]  data_rd_ptr;
    logic [5:0]  data_count;
    logic [31:0] cmd_words [CMD_FIFO_DEPTH_DEF];
    logic [2:0]  cmd_wr_ptr;
    logic [2:0]  cmd_rd_ptr;
    logic [3:0]  cmd_count;
    logic [31:0] status_word;
    logic [31:0] control_word;
    logic [31:0] resp_words [4];
    logic [31:0] last_word;
    out_item_t   pending_results[$];
    int          errors;
    int          compared;
    int          seen_overflow;
    int          seen_underflow;
    int          seen_iop;
    int          seen_bad;

    function new();
      data_wr_ptr = '0;
      data_rd_ptr = '0;
      data_count = '0;
      cmd_wr_ptr = '0;
      cmd_rd_ptr = '0;
      cmd_count = '0;
      status_word = '0;
      control_word = '0;
      last_word = '0;
      for (int i = 0; i < 4; i++) resp_words[i] = '0;
      errors = 0;
      compared = 0;
      seen_overflow = 0;
      seen_underflow = 0;
      seen_iop = 0;
      seen_bad = 0;
    endfunction

    function logic push_data(logic [31:0] w);
      if (data_count >= DATA_FIFO_DEPTH_DEF) return 1'b1;
      data_words[data_wr_ptr] = w;
      data_wr_ptr = (data_wr_ptr == DATA_FIFO_DEPTH_DEF - 1) ? '0 : data_wr_ptr + 1'b1;
      data_count = data_count + 1'b1;
      return 1'b0;
    endfunction

    function logic [31:0] pop_data(output logic irq);
      logic [31:0] w;
      irq = 1'b0;
      if (data_count == 0) return last_word;
      w = data_words[data_rd_ptr];
      data_rd_ptr = (data_rd_ptr == DATA_FIFO_DEPTH_DEF - 1) ? '0 : data_rd_ptr + 1'b1;
      data_count = data_count - 1'b1;
      if (w[31:24] == IRQ1_TAG) begin
        status_word[ST_IRQ1] = 1'b1;
        irq = 1'b1;
      end
      return w;
    endfunction

    function out_item_t predict(in_item_t acc);
      out_item_t res;
      logic [31:0] wd;
      logic [31:0] w;
      logic [1:0]  dir;
      logic        req;
      res = '0;
      wd = acc.write_data;
      case (acc.opcode)
        OP_GPU_WR: begin
          if (acc.reg_select == SEL_GPU_DATA) begin
            res.fifo_overflow = push_data(wd);
          end else if (acc.reg_select == SEL_GPU_STAT) begin
            if (wd[29:28] == CMD_CLASS_IMM) begin
              case (wd[2:0])
                SEL_RESP_E2: last_word = resp_words[0] & MASK_E2;
                SEL_RESP_E3: last_word = resp_words[1] & MASK_E3E4;
                SEL_RESP_E4: last_word = resp_words[2] & MASK_E3E4;
                SEL_RESP_E5: last_word = resp_words[3] & MASK_E5;
                default: ;
              endcase
            end else begin
              res.host_irq = 1'b1;
              if (cmd_count >= CMD_FIFO_DEPTH_DEF) begin
                res.fifo_overflow = 1'b1;
              end else begin
                cmd_words[cmd_wr_ptr] = wd;
                cmd_wr_ptr = (cmd_wr_ptr == CMD_FIFO_DEPTH_DEF - 1) ? '0 : cmd_wr_ptr + 1'b1;
                cmd_count = cmd_count + 1'b1;
              end
            end
          end else begin
            res.bad_access = 1'b1;
          end
        end
        OP_GPU_RD: begin
          if (acc.reg_select == SEL_GPU_DATA) begin
            res.read_data = pop_data(res.iop_irq);
          end else if (acc.reg_select == SEL_GPU_STAT) begin
            status_word[ST_RSEND] = control_word[CT_GPU_RDY];
            res.read_data = status_word;
          end else begin
            res.bad_access = 1'b1;
          end
        end
        OP_HOST_WR: begin
          case (acc.reg_select)
            SEL_HOST_STAT: status_word = wd;
            SEL_HOST_CTRL: control_word = wd;
            SEL_RESP_E2, SEL_RESP_E3, SEL_RESP_E4, SEL_RESP_E5:
              resp_words[2'(acc.reg_select - SEL_RESP_E2)] = wd;
            SEL_CMD_FIFO: res.bad_access = 1'b1;
            default: res.fifo_overflow = push_data(wd);
          endcase
        end
        default: begin
          case (acc.reg_select)
            SEL_HOST_STAT: res.read_data = status_word;
            SEL_HOST_CTRL: begin
              control_word[12:8] = (data_count < 6'h1F) ? data_count[4:0] : 5'h1F;
              control_word[18:16] = (cmd_count < 4'd7) ? cmd_count[2:0] : 3'd7;
              res.read_data = control_word;
            end
            SEL_RESP_E2, SEL_RESP_E3, SEL_RESP_E4, SEL_RESP_E5:
              res.read_data = resp_words[2'(acc.reg_select - SEL_RESP_E2)];
            SEL_CMD_FIFO: begin
              if (cmd_count == 0) begin
                res.fifo_underflow = 1'b1;
              end else begin
                w = cmd_words[cmd_rd_ptr];
                cmd_rd_ptr = (cmd_rd_ptr == CMD_FIFO_DEPTH_DEF - 1) ? '0 : cmd_rd_ptr + 1'b1;
                cmd_count = cmd_count - 1'b1;
                if (w[29:24] == CMD_IRQ_ACK) begin
                  status_word[ST_IRQ1] = 1'b0;
                end else if (w[29:24] == CMD_DMA_DIR) begin
                  dir = w[1:0];
                  status_word[ST_DDIR_LO +: 2] = dir;
                  case (dir)
                    DIR_FIFO: req = (data_count < DATA_FIFO_DEPTH_DEF - DATA_FIFO_SPARE_DEF);
                    DIR_RDMA: req = status_word[ST_RDMA];
                    DIR_SEND: req = status_word[ST_RSEND];
                    default: req = 1'b0;
                  endcase
                  status_word[ST_DREQ] = req;
                end
                res.read_data = w;
              end
            end
            default: res.read_data = pop_data(res.iop_irq);
          endcase
        end
      endcase
      return res;
    endfunction

    function void note_access(in_item_t acc);
      out_item_t res;
      res = predict(acc);
      seen_overflow += res.fifo_overflow;
      seen_underflow += res.fifo_underflow;
      seen_iop += res.iop_irq;
      seen_bad += res.bad_access;
      pending_results.push_back(res);
    endfunction

    task report(string what, logic [31:0] exp_val, logic [31:0] got_val);
      errors++;
      if (errors <= 50)
        $display("MISMATCH at %0t: %s expected %h got %h", $realtime, what, exp_val, got_val);
    endtask

    task check_result(out_item_t got);
      out_item_t exp_res;
      if (pending_results.size() == 0) begin
        report("unexpected result, read_data", '0, got.read_data);
      end else begin
        exp_res = pending_results.pop_front();
        compared++;
        if (got.read_data !== exp_res.read_data)
          report("read_data", exp_res.read_data, got.read_data);
        if (got.host_irq !== exp_res.host_irq)
          report("host_irq", 32'(exp_res.host_irq), 32'(got.host_irq));
        if (got.iop_irq !== exp_res.iop_irq)
          report("iop_irq", 32'(exp_res.iop_irq), 32'(got.iop_irq));
        if (got.fifo_overflow !== exp_res.fifo_overflow)
          report("fifo_overflow", 32'(exp_res.fifo_overflow), 32'(got.fifo_overflow));
        if (got.fifo_underflow !== exp_res.fifo_underflow)
          report("fifo_underflow", 32'(exp_res.fifo_underflow), 32'(got.fifo_underflow));
        if (got.bad_access !== exp_res.bad_access)
          report("bad_access", 32'(exp_res.bad_access), 32'(got.bad_access));
      end
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  bridge_scoreboard sb;
  int sender_idle;
  int recv_idle;
  int accesses_sent;
  int cycles;

  gpu_port_bridge_regs_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Each result transfer is checked against the oldest expectation.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic in_item_t acc(logic [1:0] op, logic [2:0] sel, logic [31:0] wd);
    in_item_t it;
    it.opcode = op;
    it.reg_select = sel;
    it.write_data = wd;
    return it;
  endfunction

  function automatic in_item_t make_access(int kind);
    in_item_t it;
    logic [31:0] w;
    w = $urandom;
    it.opcode = OP_GPU_WR;
    it.reg_select = SEL_GPU_DATA;
    case (kind)
      ACC_DATA_PUSH: begin
        if ($urandom_range(3) == 0) w[31:24] = IRQ1_TAG;
        if ($urandom_range(4) == 0) begin
          it.opcode = OP_HOST_WR;
          it.reg_select = SEL_DATA_FIFO;
        end
      end
      ACC_DATA_POP: begin
        if ($urandom_range(1) == 0) begin
          it.opcode = OP_GPU_RD;
        end else begin
          it.opcode = OP_HOST_RD;
          it.reg_select = SEL_DATA_FIFO;
        end
      end
      ACC_CMD_PUSH: begin
        it.reg_select = SEL_GPU_STAT;
        case ($urandom_range(2))
          0: w[29:24] = CMD_IRQ_ACK;
          1: w[29:24] = CMD_DMA_DIR;
          default: ;
        endcase
        if (w[29:28] == CMD_CLASS_IMM) w[28] = 1'b0;
      end
      ACC_IMM_QUERY: begin
        it.reg_select = SEL_GPU_STAT;
        w[29:28] = CMD_CLASS_IMM;
        if ($urandom_range(1) == 0) w[2:0] = 3'($urandom_range(SEL_RESP_E2, SEL_RESP_E5));
      end
      ACC_CMD_POP: begin
        it.opcode = OP_HOST_RD;
        it.reg_select = SEL_CMD_FIFO;
      end
      ACC_HOST_REG: begin
        case ($urandom_range(2))
          0: it.opcode = OP_HOST_WR;
          1: it.opcode = OP_HOST_RD;
          default: it.opcode = OP_GPU_RD;
        endcase
        it.reg_select = (it.opcode == OP_GPU_RD) ? SEL_GPU_STAT
                                                 : 3'($urandom_range(SEL_HOST_STAT, SEL_RESP_E5));
      end
      default: begin
        it.opcode = 2'($urandom);
        it.reg_select = 3'($urandom);
      end
    endcase
    it.write_data = w;
    return it;
  endfunction

  task automatic send_access(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_access(it);
    accesses_sent++;
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic run_random(int count);
    int done;
    int kind;
    int n;
    int r;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 1) begin
        kind = ACC_DATA_PUSH;
        n = $urandom_range(33, 40);
      end else if (r < 2) begin
        kind = ACC_DATA_POP;
        n = $urandom_range(33, 40);
      end else if (r < 4) begin
        kind = ACC_CMD_PUSH;
        n = $urandom_range(8, 11);
      end else if (r < 6) begin
        kind = ACC_CMD_POP;
        n = $urandom_range(8, 11);
      end else begin
        n = 1;
        r = $urandom_range(99);
        if (r < 25) kind = ACC_DATA_PUSH;
        else if (r < 48) kind = ACC_DATA_POP;
        else if (r < 58) kind = ACC_CMD_PUSH;
        else if (r < 66) kind = ACC_IMM_QUERY;
        else if (r < 76) kind = ACC_CMD_POP;
        else if (r < 93) kind = ACC_HOST_REG;
        else kind = ACC_NOISE;
      end
      repeat (n) begin
        send_access(make_access(kind));
        done++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    sender_idle = 17;
    recv_idle = 66;
    accesses_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_access(acc(OP_HOST_RD, SEL_HOST_CTRL, 32'h0));
    send_access(acc(OP_GPU_RD, SEL_GPU_DATA, 32'h0));
    send_access(acc(OP_HOST_RD, SEL_CMD_FIFO, 32'h0));
    send_access(acc(OP_HOST_WR, SEL_RESP_E2, 32'hFFFF_FFFF));
    send_access(acc(OP_HOST_WR, SEL_RESP_E3, 32'hFFFF_FFFF));
    send_access(acc(OP_HOST_WR, SEL_RESP_E4, 32'hFFFF_FFFF));
    send_access(acc(OP_HOST_WR, SEL_RESP_E5, 32'hFFFF_FFFF));
    send_access(acc(OP_GPU_WR, SEL_GPU_STAT, 32'h1000_0002));
    send_access(acc(OP_GPU_RD, SEL_GPU_DATA, 32'h0));
    send_access(acc(OP_GPU_WR, SEL_GPU_STAT, 32'hD000_0005));
    send_access(acc(OP_GPU_WR, SEL_GPU_STAT, 32'h1000_0007));
    send_access(acc(OP_HOST_RD, SEL_DATA_FIFO, 32'hFFFF_FFFF));
    send_access(acc(OP_GPU_WR, SEL_GPU_DATA, 32'h1F00_1234));
    send_access(acc(OP_HOST_WR, SEL_DATA_FIFO, 32'hFFFF_FFFF));
    send_access(acc(OP_GPU_RD, SEL_GPU_DATA, 32'h0));
    send_access(acc(OP_HOST_RD, SEL_DATA_FIFO, 32'h0));
    send_access(acc(OP_GPU_WR, SEL_GPU_STAT, 32'h0200_0000));
    send_access(acc(OP_GPU_WR, SEL_GPU_STAT, 32'h0400_0003));
    send_access(acc(OP_GPU_WR, SEL_GPU_STAT, 32'hFF00_0001));
    send_access(acc(OP_HOST_WR, SEL_HOST_CTRL, 32'hFFFF_FFFF));
    send_access(acc(OP_GPU_RD, SEL_GPU_STAT, 32'h0));
    send_access(acc(OP_HOST_RD, SEL_CMD_FIFO, 32'h0));
    send_access(acc(OP_HOST_RD, SEL_CMD_FIFO, 32'h0));
    send_access(acc(OP_GPU_WR, SEL_RESP_E5, 32'h0));
    send_access(acc(OP_GPU_RD, SEL_DATA_FIFO, 32'h0));
    send_access(acc(OP_HOST_WR, SEL_CMD_FIFO, 32'h0));
    send_access(acc(OP_HOST_RD, SEL_HOST_STAT, 32'h0));

    run_random(484);
    sender_idle = 66;
    recv_idle = 17;
    run_random(483);
    sender_idle = 0;
    recv_idle = 0;
    run_random(483);
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d accesses under three flow-control profiles, %0d results compared.",
             accesses_sent, sb.compared);
    $display("Seen: %0d overflows, %0d underflows, %0d IOP interrupts, %0d bad accesses.",
             sb.seen_overflow, sb.seen_underflow, sb.seen_iop, sb.seen_bad);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
